[hdl/tvae_pkg.sv]
package tvae_pkg;

    // audio sample rate that the rate steps are built for
    localparam logic [63:0] SAMPLE_RATE = 64'd44100;

    // 2^24 times 1e11: full scale over times held in units of 1e-11 s
    localparam logic [63:0] FULL_SCALE = 64'd1677721600000000000;

    localparam int unsigned NUM_VOICES = 3;
    localparam int unsigned VOICE_REGS = 7;
    localparam int unsigned LEVEL_W    = 24;
    localparam int unsigned STEP_W     = 24;

    // register offsets inside a voice block
    localparam logic [2:0] OFFS_CTRL = 3'd4;
    localparam logic [2:0] OFFS_AD   = 3'd5;
    localparam logic [2:0] OFFS_SR   = 3'd6;

    // command queue between front and back
    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    // result queue at the back
    localparam int unsigned RESQ_DEPTH = 2;
    localparam int unsigned RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam int unsigned RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    // level limits, signed with headroom for the update arithmetic
    localparam logic signed [LEVEL_W+1:0] LEVEL_MAX   = 26'sd16777215;
    localparam logic signed [LEVEL_W+1:0] LEVEL_FLOOR = 26'sd262144;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CMD_GATE = 2'd0,
        CMD_AD   = 2'd1,
        CMD_SR   = 2'd2,
        CMD_TICK = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [1:0] voice;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic [NUM_VOICES-1:0][LEVEL_W-1:0] level;
        t_phase [NUM_VOICES-1:0]            phase;
    } t_result;

    // attack steps per sample, truncated
    localparam logic [STEP_W-1:0] ATK_STEP [16] = '{
        STEP_W'(FULL_SCALE / (64'd225286060    * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd800995770    * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd1576960420   * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd2377956190   * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd3729636550   * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd5506845910   * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd6683308450   * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd7834739870   * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd9812198180   * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd24455402100  * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd48910804200  * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd78247274200  * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd97771546100  * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd293364701000 * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd488907793000 * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd782272493000 * SAMPLE_RATE))
    };

    // decay and release steps per sample, truncated
    localparam logic [STEP_W-1:0] DR_STEP [16] = '{
        STEP_W'(FULL_SCALE / (64'd891777693     * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd2459405100    * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd4841859070    * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd7301166390    * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd11451247500   * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd16907835600   * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd20519943200   * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd24055197500   * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd30126612500   * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd75085824500   * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd150171551000  * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd240243682000  * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd300189298000  * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd900721405000  * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd1501099800000 * SAMPLE_RATE)),
        STEP_W'(FULL_SCALE / (64'd2401821110000 * SAMPLE_RATE))
    };

    function automatic logic [STEP_W-1:0] atk_step(input logic [3:0] idx);
        return ATK_STEP[idx];
    endfunction

    function automatic logic [STEP_W-1:0] dr_step(input logic [3:0] idx);
        return DR_STEP[idx];
    endfunction

endpackage

[hdl/tvae_front.sv]
// Classifies an incoming word: tick, one of the kept register writes, or dropped
module tvae_front (
    input  logic              i_operation,
    input  logic [4:0]        i_reg_addr,
    input  logic [7:0]        i_write_data,
    output logic              o_keep,
    output tvae_pkg::t_cmd    o_cmd
);

    logic [4:0] w_offs;
    logic [1:0] w_voice;
    logic       w_in_range;

    // split the address into voice and offset by compare and subtract
    always_comb begin
        w_in_range = (i_reg_addr < 5'(3 * tvae_pkg::VOICE_REGS));
        if (i_reg_addr < 5'(tvae_pkg::VOICE_REGS)) begin
            w_voice = 2'd0;
            w_offs  = i_reg_addr;
        end else if (i_reg_addr < 5'(2 * tvae_pkg::VOICE_REGS)) begin
            w_voice = 2'd1;
            w_offs  = i_reg_addr - 5'(tvae_pkg::VOICE_REGS);
        end else begin
            w_voice = 2'd2;
            w_offs  = i_reg_addr - 5'(2 * tvae_pkg::VOICE_REGS);
        end
    end

    // build the command
    always_comb begin
        o_cmd.voice = w_voice;
        o_cmd.data  = i_write_data;
        o_cmd.kind  = tvae_pkg::CMD_TICK;
        o_keep      = 1'b0;
        if (tvae_pkg::t_op'(i_operation) == tvae_pkg::OP_TICK) begin
            o_keep = 1'b1;
        end else if (w_in_range) begin
            priority if (w_offs[2:0] == tvae_pkg::OFFS_CTRL && w_offs[4:3] == 2'd0) begin
                o_cmd.kind = tvae_pkg::CMD_GATE;
                o_keep     = 1'b1;
            end else if (w_offs[2:0] == tvae_pkg::OFFS_AD && w_offs[4:3] == 2'd0) begin
                o_cmd.kind = tvae_pkg::CMD_AD;
                o_keep     = 1'b1;
            end else if (w_offs[2:0] == tvae_pkg::OFFS_SR && w_offs[4:3] == 2'd0) begin
                o_cmd.kind = tvae_pkg::CMD_SR;
                o_keep     = 1'b1;
            end else begin
                o_keep = 1'b0;
            end
        end
    end

endmodule

[hdl/tvae_cmd_queue.sv]
// Short command queue between front and back
module tvae_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tvae_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tvae_pkg::t_cmd o_cmd
);

    tvae_pkg::t_cmd                r_mem [tvae_pkg::CMDQ_DEPTH];
    logic [tvae_pkg::CMDQ_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [tvae_pkg::CMDQ_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [tvae_pkg::CMDQ_CW-1:0] r_count, n_count;
    logic                          w_push, w_pop;

    assign o_full  = (r_count == tvae_pkg::CMDQ_CW'(tvae_pkg::CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr + tvae_pkg::CMDQ_AW'(w_push);
        n_rd_ptr = r_rd_ptr + tvae_pkg::CMDQ_AW'(w_pop);
        n_count  = r_count + tvae_pkg::CMDQ_CW'(w_push) - tvae_pkg::CMDQ_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[hdl/tvae_voice.sv]
// One envelope step for one voice
module tvae_voice (
    input  logic                           i_gate,
    input  logic [7:0]                     i_ad,
    input  logic [7:0]                     i_sr,
    input  logic [tvae_pkg::LEVEL_W-1:0]   i_level,
    input  tvae_pkg::t_phase               i_phase,
    output logic [tvae_pkg::LEVEL_W-1:0]   o_level,
    output tvae_pkg::t_phase               o_phase
);

    logic signed [tvae_pkg::LEVEL_W+1:0] w_cur;
    logic signed [tvae_pkg::LEVEL_W+1:0] w_sus;
    logic signed [tvae_pkg::LEVEL_W+1:0] w_sum;
    logic signed [tvae_pkg::LEVEL_W+1:0] w_dec;
    logic signed [tvae_pkg::LEVEL_W+1:0] w_rel;
    logic signed [tvae_pkg::LEVEL_W+1:0] w_new;
    tvae_pkg::t_phase                    w_ph;

    assign w_cur = $signed({2'b00, i_level});
    assign w_sus = $signed({2'b00, i_sr[7:4], 20'd0});
    assign w_sum = w_cur + $signed({2'b00, tvae_pkg::atk_step(i_ad[7:4])});
    assign w_dec = w_cur - $signed({2'b00, tvae_pkg::dr_step(i_ad[3:0])});
    assign w_rel = w_cur - $signed({2'b00, tvae_pkg::dr_step(i_sr[3:0])});

    // gate forces release when clear, restarts attack when set in release
    always_comb begin
        if (!i_gate) begin
            w_ph = tvae_pkg::PH_RELEASE;
        end else if (i_phase == tvae_pkg::PH_RELEASE) begin
            w_ph = tvae_pkg::PH_ATTACK;
        end else begin
            w_ph = i_phase;
        end
    end

    // phase update with clamps
    always_comb begin
        w_new   = w_cur;
        o_phase = w_ph;
        unique case (w_ph)
            tvae_pkg::PH_ATTACK: begin
                w_new = w_sum;
                if (w_sum >= tvae_pkg::LEVEL_MAX) begin
                    w_new   = tvae_pkg::LEVEL_MAX;
                    o_phase = tvae_pkg::PH_DECAY;
                end
            end
            tvae_pkg::PH_DECAY: begin
                w_new = w_dec;
                if (w_dec <= w_sus) begin
                    w_new   = w_sus;
                    o_phase = tvae_pkg::PH_SUSTAIN;
                end
            end
            tvae_pkg::PH_SUSTAIN: begin
                if (w_cur != w_sus) begin
                    o_phase = tvae_pkg::PH_DECAY;
                end
            end
            tvae_pkg::PH_RELEASE: begin
                w_new = w_rel;
                if (w_rel < tvae_pkg::LEVEL_FLOOR) begin
                    w_new = tvae_pkg::LEVEL_FLOOR;
                end
            end
            default: begin
                w_new = w_cur;
            end
        endcase
    end

    // every arm leaves the level inside 0 .. 0xFFFFFF
    assign o_level = w_new[tvae_pkg::LEVEL_W-1:0];

endmodule

[hdl/tvae_back.sv]
// Carries out commands: voice register writes and envelope ticks, with a result queue
module tvae_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  tvae_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output tvae_pkg::t_result o_result
);

    localparam int unsigned NV = tvae_pkg::NUM_VOICES;
    localparam int unsigned LW = tvae_pkg::LEVEL_W;

    logic [NV-1:0]              r_gate, n_gate;
    logic [NV-1:0][7:0]         r_ad, n_ad;
    logic [NV-1:0][7:0]         r_sr, n_sr;
    logic [NV-1:0][LW-1:0]      r_level, n_level;
    tvae_pkg::t_phase [NV-1:0]  r_phase, n_phase;

    logic [NV-1:0][LW-1:0]      w_step_level;
    tvae_pkg::t_phase [NV-1:0]  w_step_phase;

    tvae_pkg::t_result             r_res [tvae_pkg::RESQ_DEPTH];
    logic [tvae_pkg::RESQ_AW-1:0] r_res_wr, r_res_rd;
    logic [tvae_pkg::RESQ_CW-1:0] r_res_count;
    logic                          w_room, w_tick, w_res_push, w_res_pop;

    // take a command unless it is a tick with no room for its result
    assign w_room     = (r_res_count != tvae_pkg::RESQ_CW'(tvae_pkg::RESQ_DEPTH));
    assign w_tick     = (i_cmd.kind == tvae_pkg::CMD_TICK);
    assign o_cmd_pop  = i_cmd_valid && (!w_tick || w_room);
    assign w_res_push = o_cmd_pop && w_tick;
    assign o_empty    = (r_res_count == '0);
    assign w_res_pop  = i_pop && !o_empty;
    assign o_result   = r_res[r_res_rd];

    // envelope units, one per voice
    for (genvar g = 0; g < NV; g++) begin : g_voice
        tvae_voice u_voice (
            .i_gate  (r_gate[g]),
            .i_ad    (r_ad[g]),
            .i_sr    (r_sr[g]),
            .i_level (r_level[g]),
            .i_phase (r_phase[g]),
            .o_level (w_step_level[g]),
            .o_phase (w_step_phase[g])
        );
    end

    // voice state next values
    always_comb begin
        n_gate  = r_gate;
        n_ad    = r_ad;
        n_sr    = r_sr;
        n_level = r_level;
        n_phase = r_phase;
        if (o_cmd_pop) begin
            for (int v = 0; v < NV; v++) begin
                if (i_cmd.voice == 2'(v)) begin
                    unique case (i_cmd.kind)
                        tvae_pkg::CMD_GATE: n_gate[v] = i_cmd.data[0];
                        tvae_pkg::CMD_AD:   n_ad[v]   = i_cmd.data;
                        tvae_pkg::CMD_SR:   n_sr[v]   = i_cmd.data;
                        default: ;
                    endcase
                end
            end
            if (w_tick) begin
                n_level = w_step_level;
                n_phase = w_step_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate  <= '0;
            r_ad    <= '0;
            r_sr    <= '0;
            r_level <= '0;
            r_phase <= {NV{tvae_pkg::PH_ATTACK}};
        end else begin
            r_gate  <= n_gate;
            r_ad    <= n_ad;
            r_sr    <= n_sr;
            r_level <= n_level;
            r_phase <= n_phase;
        end
    end

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr    <= '0;
            r_res_rd    <= '0;
            r_res_count <= '0;
        end else begin
            r_res_wr    <= r_res_wr + tvae_pkg::RESQ_AW'(w_res_push);
            r_res_rd    <= r_res_rd + tvae_pkg::RESQ_AW'(w_res_pop);
            r_res_count <= r_res_count + tvae_pkg::RESQ_CW'(w_res_push)
                           - tvae_pkg::RESQ_CW'(w_res_pop);
        end
    end

    // result words
    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_res[r_res_wr].level <= w_step_level;
            r_res[r_res_wr].phase <= w_step_phase;
        end
    end

endmodule

[hdl/three_voice_adsr_envelope.sv]
// Channel  Handshake        Word
// input    push / full      i_operation, i_reg_addr, i_write_data
// result   empty / pop      o_level_voice0..2, o_phase_voice0..2
//
// One word a cycle on each side while its flag, full or empty, is low. A kept
// word enters the command queue in the cycle it is taken; the back end works
// the queue head, and a tick's result is registered as the tick is popped.
// The three voice updates run in parallel. Reset is synchronous and clears
// all voice state. full rises when the four-entry command queue fills; the
// back end stops at a tick only while the two-entry result queue is full.
module three_voice_adsr_envelope (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_operation,
    input  logic [4:0]  i_reg_addr,
    input  logic [7:0]  i_write_data,
    output logic        empty,
    input  logic        pop,
    output logic [23:0] o_level_voice0,
    output logic [23:0] o_level_voice1,
    output logic [23:0] o_level_voice2,
    output logic [1:0]  o_phase_voice0,
    output logic [1:0]  o_phase_voice1,
    output logic [1:0]  o_phase_voice2
);

    logic              w_keep;
    tvae_pkg::t_cmd    w_front_cmd;
    logic              w_q_valid;
    tvae_pkg::t_cmd    w_q_cmd;
    logic              w_q_pop;
    tvae_pkg::t_result w_result;

    // classify incoming words
    tvae_front u_front (
        .i_operation  (i_operation),
        .i_reg_addr   (i_reg_addr),
        .i_write_data (i_write_data),
        .o_keep       (w_keep),
        .o_cmd        (w_front_cmd)
    );

    // dropped writes are taken but never queued
    tvae_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && w_keep),
        .i_cmd   (w_front_cmd),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    tvae_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (w_result)
    );

    assign o_level_voice0 = w_result.level[0];
    assign o_level_voice1 = w_result.level[1];
    assign o_level_voice2 = w_result.level[2];
    assign o_phase_voice0 = w_result.phase[0];
    assign o_phase_voice1 = w_result.phase[1];
    assign o_phase_voice2 = w_result.phase[2];

endmodule

[hdl/tvae_checker.sv]
// Port-level checks on the envelope block
module tvae_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [23:0] o_level_voice0,
    input logic [23:0] o_level_voice1,
    input logic [23:0] o_level_voice2,
    input logic [1:0]  o_phase_voice0,
    input logic [1:0]  o_phase_voice1,
    input logic [1:0]  o_phase_voice2
);

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting after reset");

    // a waiting word holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_level_voice0) && $stable(o_level_voice1)
            && $stable(o_level_voice2) && $stable(o_phase_voice0)
            && $stable(o_phase_voice1) && $stable(o_phase_voice2))
        else $error("result word changed while stalled");

    // release never drops below the floor
    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_phase_voice0 != tvae_pkg::PH_RELEASE || o_level_voice0 >= 24'h040000)
            && (o_phase_voice1 != tvae_pkg::PH_RELEASE || o_level_voice1 >= 24'h040000)
            && (o_phase_voice2 != tvae_pkg::PH_RELEASE || o_level_voice2 >= 24'h040000))
        else $error("release level under floor");

    // reaching full scale always leaves attack
    a_attack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_phase_voice0 != tvae_pkg::PH_ATTACK || o_level_voice0 != 24'hFFFFFF)
            && (o_phase_voice1 != tvae_pkg::PH_ATTACK || o_level_voice1 != 24'hFFFFFF)
            && (o_phase_voice2 != tvae_pkg::PH_ATTACK || o_level_voice2 != 24'hFFFFFF))
        else $error("attack at full scale");

    // sustain sits on a nibble level
    a_sustain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_phase_voice0 != tvae_pkg::PH_SUSTAIN || o_level_voice0[19:0] == 20'd0)
            && (o_phase_voice1 != tvae_pkg::PH_SUSTAIN || o_level_voice1[19:0] == 20'd0)
            && (o_phase_voice2 != tvae_pkg::PH_SUSTAIN || o_level_voice2[19:0] == 20'd0))
        else $error("sustain level off grid");

endmodule

bind three_voice_adsr_envelope tvae_checker u_tvae_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_level_voice0 (o_level_voice0),
    .o_level_voice1 (o_level_voice1),
    .o_level_voice2 (o_level_voice2),
    .o_phase_voice0 (o_phase_voice0),
    .o_phase_voice1 (o_phase_voice1),
    .o_phase_voice2 (o_phase_voice2)
);

[dv/three_voice_adsr_envelope_tb.sv]
module three_voice_adsr_envelope_tb;

    localparam int NUM_WORDS     = 1350;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;

    localparam longint unsigned FULL_SCALE_E11 = 64'd1677721600000000000;
    localparam longint          ENV_MAX        = 64'sd16777215;
    localparam longint          ENV_FLOOR      = 64'sd262144;

    typedef enum logic [1:0] {
        IDLE_NONE = 2'd0,
        IDLE_SEND = 2'd1,
        IDLE_RECV = 2'd2,
        IDLE_BOTH = 2'd3
    } t_idle_mode;

    typedef struct packed {
        tvae_pkg::t_op op;
        logic [4:0]    addr;
        logic [7:0]    data;
        t_idle_mode    mode;
    } t_bus_word;

    typedef struct packed {
        logic [2:0][23:0] lvl;
        logic [2:0][1:0]  ph;
    } t_env_result;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic        i_operation  = 1'b0;
    logic [4:0]  i_reg_addr   = 5'd0;
    logic [7:0]  i_write_data = 8'd0;
    logic        empty;
    logic        pop          = 1'b0;
    logic [23:0] o_level_voice0, o_level_voice1, o_level_voice2;
    logic [1:0]  o_phase_voice0, o_phase_voice1, o_phase_voice2;

    three_voice_adsr_envelope dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_operation    (i_operation),
        .i_reg_addr     (i_reg_addr),
        .i_write_data   (i_write_data),
        .empty          (empty),
        .pop            (pop),
        .o_level_voice0 (o_level_voice0),
        .o_level_voice1 (o_level_voice1),
        .o_level_voice2 (o_level_voice2),
        .o_phase_voice0 (o_phase_voice0),
        .o_phase_voice1 (o_phase_voice1),
        .o_phase_voice2 (o_phase_voice2)
    );

    // stage times in units of 1e-11 s
    longint unsigned attack_e11 [16] = '{
        64'd225286060,    64'd800995770,    64'd1576960420,   64'd2377956190,
        64'd3729636550,   64'd5506845910,   64'd6683308450,   64'd7834739870,
        64'd9812198180,   64'd24455402100,  64'd48910804200,  64'd78247274200,
        64'd97771546100,  64'd293364701000, 64'd488907793000, 64'd782272493000
    };
    longint unsigned decrel_e11 [16] = '{
        64'd891777693,     64'd2459405100,    64'd4841859070,    64'd7301166390,
        64'd11451247500,   64'd16907835600,   64'd20519943200,   64'd24055197500,
        64'd30126612500,   64'd75085824500,   64'd150171551000,  64'd240243682000,
        64'd300189298000,  64'd900721405000,  64'd1501099800000, 64'd2401821110000
    };

    // envelope state as the block should hold it
    logic             gate_r [3];
    logic [7:0]       ad_r   [3];
    logic [7:0]       sr_r   [3];
    longint           env_lvl [3];
    tvae_pkg::t_phase env_ph  [3];

    t_bus_word   pending_q  [$];
    t_env_result expected_q [$];
    t_idle_mode  fill_mode  = IDLE_NONE;
    t_idle_mode  rx_mode    = IDLE_NONE;
    int          counted    = 0;
    int          err_cnt    = 0;

    function automatic longint rate_step(input longint unsigned t);
        return longint'(FULL_SCALE_E11 / (t * tvae_pkg::SAMPLE_RATE));
    endfunction

    function automatic void clear_envelopes();
        for (int v = 0; v < 3; v++) begin
            gate_r[v]  = 1'b0;
            ad_r[v]    = 8'h00;
            sr_r[v]    = 8'h00;
            env_lvl[v] = 0;
            env_ph[v]  = tvae_pkg::PH_ATTACK;
        end
    endfunction

    // one sample of one voice
    function automatic void step_voice(input int v);
        longint lvl;
        longint sus;
        tvae_pkg::t_phase ph;
        lvl = env_lvl[v];
        sus = longint'({sr_r[v][7:4], 20'h00000});
        ph  = env_ph[v];
        if (!gate_r[v]) ph = tvae_pkg::PH_RELEASE;
        else if (ph == tvae_pkg::PH_RELEASE) ph = tvae_pkg::PH_ATTACK;
        case (ph)
            tvae_pkg::PH_ATTACK: begin
                lvl += rate_step(attack_e11[ad_r[v][7:4]]);
                if (lvl >= ENV_MAX) begin
                    lvl = ENV_MAX;
                    ph  = tvae_pkg::PH_DECAY;
                end
            end
            tvae_pkg::PH_DECAY: begin
                lvl -= rate_step(decrel_e11[ad_r[v][3:0]]);
                if (lvl <= sus) begin
                    lvl = sus;
                    ph  = tvae_pkg::PH_SUSTAIN;
                end
            end
            tvae_pkg::PH_SUSTAIN: begin
                if (lvl != sus) ph = tvae_pkg::PH_DECAY;
            end
            default: begin
                lvl -= rate_step(decrel_e11[sr_r[v][3:0]]);
                if (lvl < ENV_FLOOR) lvl = ENV_FLOOR;
            end
        endcase
        if (lvl < 0) lvl = 0;
        if (lvl > ENV_MAX) lvl = ENV_MAX;
        env_lvl[v] = lvl;
        env_ph[v]  = ph;
    endfunction

    // register write or sample tick; a tick queues the levels it should give
    function automatic void predict_envelopes(input t_bus_word w);
        int          voice;
        int          offs;
        t_env_result r;
        if (w.op == tvae_pkg::OP_WRITE) begin
            if (w.addr <= 5'd20) begin
                voice = int'(w.addr) / 7;
                offs  = int'(w.addr) % 7;
                if (offs == int'(tvae_pkg::OFFS_CTRL)) gate_r[voice] = w.data[0];
                else if (offs == int'(tvae_pkg::OFFS_AD)) ad_r[voice] = w.data;
                else if (offs == int'(tvae_pkg::OFFS_SR)) sr_r[voice] = w.data;
            end
        end else begin
            for (int v = 0; v < 3; v++) step_voice(v);
            for (int v = 0; v < 3; v++) begin
                r.lvl[v] = env_lvl[v][23:0];
                r.ph[v]  = env_ph[v];
            end
            expected_q.push_back(r);
        end
    endfunction

    function automatic int send_idle_pct(input t_idle_mode m);
        return (m == IDLE_SEND) ? 47 : (m == IDLE_BOTH) ? 15 : 0;
    endfunction

    function automatic int recv_stall_pct(input t_idle_mode m);
        return (m == IDLE_RECV) ? 47 : (m == IDLE_BOTH) ? 15 : 0;
    endfunction

    // stimulus helpers
    task automatic add_word(input tvae_pkg::t_op op, input int addr, input int data);
        t_bus_word w;
        w.op   = op;
        w.addr = addr[4:0];
        w.data = data[7:0];
        w.mode = fill_mode;
        pending_q.push_back(w);
        // ignored offsets do not count towards the word total
        if (op == tvae_pkg::OP_TICK || (addr <= 20 && addr % 7 >= 4)) counted++;
    endtask

    task automatic add_ticks(input int n);
        repeat (n) add_word(tvae_pkg::OP_TICK, $urandom_range(0, 31), $urandom_range(0, 255));
    endtask

    // rate nibble leaning towards the quick end so that stages complete
    function automatic int quick_nibble();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 75) return 1;
        return $urandom_range(0, 15);
    endfunction

    // one note on one voice: set rates, gate on, hold, gate off, let it fade
    task automatic add_note(input int v);
        int base;
        base = 7 * v;
        add_word(tvae_pkg::OP_WRITE, base + int'(tvae_pkg::OFFS_AD),
                 quick_nibble() * 16 + quick_nibble());
        add_word(tvae_pkg::OP_WRITE, base + int'(tvae_pkg::OFFS_SR),
                 $urandom_range(0, 15) * 16 + quick_nibble());
        add_word(tvae_pkg::OP_WRITE, base + int'(tvae_pkg::OFFS_CTRL),
                 $urandom_range(0, 255) | 1);
        add_ticks($urandom_range(10, 140));
        // sustain moved while held, upwards included
        if ($urandom_range(0, 3) == 0) begin
            add_word(tvae_pkg::OP_WRITE, base + int'(tvae_pkg::OFFS_SR),
                     $urandom_range(0, 15) * 16 + quick_nibble());
            add_ticks($urandom_range(2, 30));
        end
        add_word(tvae_pkg::OP_WRITE, base + int'(tvae_pkg::OFFS_CTRL),
                 $urandom_range(0, 255) & 8'hFE);
        add_ticks($urandom_range(3, 60));
    endtask

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // driver: offers the head of the pending queue, predicts on acceptance
    always @(posedge i_clk) begin
        t_bus_word w;
        if (!i_rst_n) begin
            push <= 1'b0;
            clear_envelopes();
        end else begin
            if (push && !full) begin
                w = pending_q.pop_front();
                predict_envelopes(w);
                rx_mode <= w.mode;
            end
            if (pending_q.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct(pending_q[0].mode)) begin
                push         <= 1'b1;
                i_operation  <= pending_q[0].op;
                i_reg_addr   <= pending_q[0].addr;
                i_write_data <= pending_q[0].data;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor: checks each popped word against the oldest expected levels
    always @(posedge i_clk) begin
        t_env_result want;
        t_env_result got;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got.lvl = {o_level_voice2, o_level_voice1, o_level_voice0};
                got.ph  = {o_phase_voice2, o_phase_voice1, o_phase_voice0};
                if (expected_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("unexpected word: level %h %h %h phase %0d %0d %0d",
                                 got.lvl[0], got.lvl[1], got.lvl[2],
                                 got.ph[0], got.ph[1], got.ph[2]);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display({"mismatch: level %h %h %h phase %0d %0d %0d,",
                                      " expected level %h %h %h phase %0d %0d %0d"},
                                     got.lvl[0], got.lvl[1], got.lvl[2],
                                     got.ph[0], got.ph[1], got.ph[2],
                                     want.lvl[0], want.lvl[1], want.lvl[2],
                                     want.ph[0], want.ph[1], want.ph[2]);
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_stall_pct(rx_mode));
        end
    end

    // stimulus, reset and end of run
    initial begin
        int pick;
        int v;

        // directed: ignored offsets, gate bit alone, extremes of the rates
        add_word(tvae_pkg::OP_TICK, 0, 0);      // released from reset: raised to floor
        add_word(tvae_pkg::OP_WRITE, 0, 8'hFF);
        add_word(tvae_pkg::OP_WRITE, 31, 8'hFF);
        add_word(tvae_pkg::OP_WRITE, 21, 8'h00);
        add_word(tvae_pkg::OP_WRITE, 7, 8'hA5);
        add_word(tvae_pkg::OP_WRITE, 5, 8'h00);
        add_word(tvae_pkg::OP_WRITE, 6, 8'hF0);
        add_word(tvae_pkg::OP_WRITE, 4, 8'hFE); // upper control bits only, gate stays off
        add_word(tvae_pkg::OP_TICK, 31, 8'hFF);
        add_word(tvae_pkg::OP_WRITE, 4, 8'h01);
        add_word(tvae_pkg::OP_WRITE, 12, 8'hFF);
        add_word(tvae_pkg::OP_WRITE, 13, 8'h0F);
        add_word(tvae_pkg::OP_WRITE, 11, 8'hFF);
        add_word(tvae_pkg::OP_WRITE, 19, 8'h0F);
        add_word(tvae_pkg::OP_WRITE, 20, 8'h5A);
        add_word(tvae_pkg::OP_WRITE, 18, 8'h81);
        add_word(tvae_pkg::OP_TICK, 0, 0);
        add_word(tvae_pkg::OP_TICK, 0, 0);
        add_word(tvae_pkg::OP_WRITE, 4, 8'h00); // gate dropped during attack
        add_word(tvae_pkg::OP_TICK, 0, 0);
        add_word(tvae_pkg::OP_WRITE, 4, 8'h01); // gate back on from release
        add_word(tvae_pkg::OP_TICK, 0, 0);
        add_word(tvae_pkg::OP_WRITE, 20, 8'hF0); // sustain raised
        add_word(tvae_pkg::OP_TICK, 0, 0);

        // random notes across the idling phases, with some noise
        while (counted < NUM_WORDS) begin
            fill_mode = t_idle_mode'((counted * 8 / NUM_WORDS) % 4);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 4))
                    add_word(tvae_pkg::t_op'($urandom_range(0, 1)), $urandom_range(0, 31),
                             $urandom_range(0, 255));
            end else begin
                v = $urandom_range(0, 2);
                add_note(v);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (!empty) err_cnt++;

        if (err_cnt == 0) begin
            $display("three_voice_adsr_envelope_tb: clean");
        end else begin
            $display("three_voice_adsr_envelope_tb: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("three_voice_adsr_envelope_tb: errors");
        $finish;
    end

endmodule

[files.f]
hdl/tvae_pkg.sv
hdl/tvae_front.sv
hdl/tvae_cmd_queue.sv
hdl/tvae_voice.sv
hdl/tvae_back.sv
hdl/three_voice_adsr_envelope.sv
hdl/tvae_checker.sv
dv/three_voice_adsr_envelope_tb.sv
